>>> rtl/calendar_date_stepper_core_assert.svh
// assertion macros for the calendar date stepper checker
// each macro expects clk and rst to be visible where it is used
`ifndef CALENDAR_DATE_STEPPER_CORE_ASSERT_SVH
`define CALENDAR_DATE_STEPPER_CORE_ASSERT_SVH

// same-cycle implication
`define CDS_ASSERT_IMP(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error(msg);

// next-cycle implication
`define CDS_ASSERT_NXT(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error(msg);

`endif

>>> rtl/cds_pkg.sv
// shared types, operation codes and calendar tables for the date stepper
// no dependencies
package cds_pkg;

  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_ADD  = 2'd1;
  localparam logic [1:0] FUNC_SUB  = 2'd2;
  localparam logic [1:0] FUNC_DIFF = 2'd3;

  // year / 100 as (year * RECIP_100) >> RECIP_SHIFT, exact for 14-bit years
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam int          RECIP_SHIFT = 19;

  typedef struct packed {
    logic latch;
    logic split;
    logic check;
    logic serial;
    logic finish_diff;
    logic step;
    logic step_end;
  } cds_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       cnt_zero;
    logic       at_bound;
  } cds_status_t;

  function automatic logic [4:0] days_in_month(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd2:                                         len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:                      len = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12:   len = 5'd31;
      default:                                      len = 5'd0;
    endcase
    return len;
  endfunction

  // days from 1 march to the first of month m, year taken as starting in march
  function automatic logic [8:0] march_offset(input logic [3:0] m);
    logic [8:0] off;
    case (m)
      4'd3:    off = 9'd0;
      4'd4:    off = 9'd31;
      4'd5:    off = 9'd61;
      4'd6:    off = 9'd92;
      4'd7:    off = 9'd122;
      4'd8:    off = 9'd153;
      4'd9:    off = 9'd184;
      4'd10:   off = 9'd214;
      4'd11:   off = 9'd245;
      4'd12:   off = 9'd275;
      4'd1:    off = 9'd306;
      4'd2:    off = 9'd337;
      default: off = 9'd0;
    endcase
    return off;
  endfunction

endpackage

>>> rtl/cds_ctrl.sv
// sequencing state machine for the date stepper
// depends on cds_pkg for the command and status structs and operation codes
module cds_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [1:0]          func,
  input  cds_pkg::cds_status_t status,
  output cds_pkg::cds_cmd_t    cmd,
  output logic                busy
);
  import cds_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SPLIT  = 3'd1;
  localparam logic [2:0] ST_CHECK  = 3'd2;
  localparam logic [2:0] ST_SERIAL = 3'd3;
  localparam logic [2:0] ST_ABS    = 3'd4;
  localparam logic [2:0] ST_STEP   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = (func == FUNC_ADD || func == FUNC_SUB) ? ST_STEP : ST_SPLIT;
        end
      end
      ST_SPLIT: begin
        cmd.split  = 1'b1;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        cmd.check  = 1'b1;
        state_next = (status.op == FUNC_LOAD) ? ST_IDLE : ST_SERIAL;
      end
      ST_SERIAL: begin
        cmd.serial = 1'b1;
        state_next = ST_ABS;
      end
      ST_ABS: begin
        cmd.finish_diff = 1'b1;
        state_next      = ST_IDLE;
      end
      ST_STEP: begin
        if (status.cnt_zero || status.at_bound) begin
          cmd.step_end = 1'b1;
          state_next   = ST_IDLE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ST_IDLE);

endmodule

>>> rtl/cds_datapath.sv
// date registers, day stepping, validity check and day-number arithmetic
// depends on cds_pkg; driven by cds_ctrl through the command struct
module cds_datapath #(
  parameter int unsigned EPOCH_YEAR = 1970,
  parameter int unsigned MAX_YEAR   = 9999,
  parameter int unsigned MAX_STEP   = 65535
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cds_pkg::cds_cmd_t    cmd,
  input  logic [1:0]           func,
  input  logic [4:0]           in_day,
  input  logic [3:0]           in_month,
  input  logic [13:0]          in_year,
  input  logic [15:0]          day_count,
  output cds_pkg::cds_status_t status,
  output logic [4:0]           out_day,
  output logic [3:0]           out_month,
  output logic [13:0]          out_year,
  output logic [21:0]          day_diff,
  output logic                 clamped,
  output logic                 done
);
  import cds_pkg::*;

  localparam logic [13:0] EPOCH_Y  = 14'(EPOCH_YEAR);
  localparam logic [13:0] MAX_Y    = 14'(MAX_YEAR);
  localparam logic [7:0]  EPOCH_Q  = 8'(EPOCH_YEAR / 100);
  localparam logic [6:0]  EPOCH_R  = 7'(EPOCH_YEAR % 100);
  localparam logic [15:0] STEP_LIM = (MAX_STEP > 65535) ? 16'hFFFF : 16'(MAX_STEP);

  // stored date, with its year split into century and year within century
  logic [4:0]  d;
  logic [3:0]  m;
  logic [13:0] y;
  logic [7:0]  q;
  logic [6:0]  r;

  // working date for load and difference
  logic [4:0]  wd;
  logic [3:0]  wm;
  logic [13:0] wy;
  logic [7:0]  wq;
  logic [6:0]  wr;
  logic        wclamp;

  logic [1:0]  op;
  logic [15:0] cnt;
  logic [22:0] ser_w;
  logic [22:0] ser_s;

  function automatic logic [22:0] serial(input logic [4:0] dd, input logic [3:0] mm,
                                         input logic [13:0] yr, input logic [7:0] cq,
                                         input logic [6:0] cr);
    logic        early;
    logic [13:0] yy;
    logic [7:0]  c;
    logic [22:0] s;
    early = (mm == 4'd1) || (mm == 4'd2);
    yy    = early ? yr - 14'd1 : yr;
    c     = (early && cr == 7'd0) ? cq - 8'd1 : cq;
    s     = {9'd0, yy} * 23'd365 + {11'd0, yy[13:2]} - {15'd0, c} + {17'd0, c[7:2]}
            + {14'd0, march_offset(mm)} + {18'd0, dd} - 23'd1;
    return s;
  endfunction

  logic [26:0] prod_q;
  logic [13:0] q100;
  logic [6:0]  wr_calc;
  logic        leap_w;
  logic [4:0]  dim_w;
  logic        valid_w;

  logic        leap_s;
  logic [4:0]  dim_s;
  logic [4:0]  dim_prev;
  logic        at_hi;
  logic        at_lo;
  logic [15:0] n_lim;
  logic [22:0] ser_delta;

  always_comb begin
    prod_q  = {13'd0, wy} * {14'd0, RECIP_100};
    q100    = {6'd0, wq} * 14'd100;
    wr_calc = 7'(wy - q100);
    leap_w  = (wr_calc[1:0] == 2'd0) && (wr_calc != 7'd0 || wq[1:0] == 2'd0);
    dim_w   = days_in_month(wm, leap_w);
    valid_w = (wy >= EPOCH_Y) && (wy <= MAX_Y) && (wm >= 4'd1) && (wm <= 4'd12)
              && (wd >= 5'd1) && (wd <= dim_w);

    leap_s   = (r[1:0] == 2'd0) && (r != 7'd0 || q[1:0] == 2'd0);
    dim_s    = days_in_month(m, leap_s);
    dim_prev = days_in_month(m - 4'd1, leap_s);
    at_hi    = (y == MAX_Y) && (m == 4'd12) && (d == 5'd31);
    at_lo    = (y == EPOCH_Y) && (m == 4'd1) && (d == 5'd1);

    n_lim     = (day_count > STEP_LIM) ? STEP_LIM : day_count;
    ser_delta = (ser_w > ser_s) ? ser_w - ser_s : ser_s - ser_w;
  end

  assign status.op       = op;
  assign status.cnt_zero = (cnt == 16'd0);
  assign status.at_bound = (op == FUNC_ADD) ? at_hi : at_lo;

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op     <= func;
      cnt    <= n_lim;
      wclamp <= 1'b0;
      wd     <= (func == FUNC_LOAD && in_day == 5'd0) ? d : in_day;
      wm     <= (func == FUNC_LOAD && in_month == 4'd0) ? m : in_month;
      wy     <= (func == FUNC_LOAD && in_year == 14'd0) ? y : in_year;
    end
    if (cmd.split) begin
      wq <= prod_q[RECIP_SHIFT+7:RECIP_SHIFT];
    end
    if (cmd.check) begin
      wclamp <= !valid_w;
      if (valid_w) begin
        wr <= wr_calc;
      end else begin
        wd <= 5'd1;
        wm <= 4'd1;
        wy <= EPOCH_Y;
        wq <= EPOCH_Q;
        wr <= EPOCH_R;
      end
    end
    if (cmd.serial) begin
      ser_w <= serial(wd, wm, wy, wq, wr);
      ser_s <= serial(d, m, y, q, r);
    end
    if (cmd.step) begin
      cnt <= cnt - 16'd1;
    end
  end

  // stored date and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      d        <= 5'd1;
      m        <= 4'd1;
      y        <= EPOCH_Y;
      q        <= EPOCH_Q;
      r        <= EPOCH_R;
      day_diff <= '0;
      clamped  <= 1'b0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.check && op == FUNC_LOAD) begin
        done     <= 1'b1;
        day_diff <= '0;
        clamped  <= !valid_w;
        if (valid_w) begin
          d <= wd;
          m <= wm;
          y <= wy;
          q <= wq;
          r <= wr_calc;
        end else begin
          d <= 5'd1;
          m <= 4'd1;
          y <= EPOCH_Y;
          q <= EPOCH_Q;
          r <= EPOCH_R;
        end
      end
      if (cmd.finish_diff) begin
        done     <= 1'b1;
        day_diff <= ser_delta[21:0];
        clamped  <= wclamp;
      end
      if (cmd.step_end) begin
        done     <= 1'b1;
        day_diff <= '0;
        // stopped on a bound with days still to go
        clamped  <= (cnt != 16'd0);
      end
      if (cmd.step) begin
        if (op == FUNC_ADD) begin
          if (d < dim_s) begin
            d <= d + 5'd1;
          end else begin
            d <= 5'd1;
            if (m == 4'd12) begin
              m <= 4'd1;
              y <= y + 14'd1;
              if (r == 7'd99) begin
                r <= 7'd0;
                q <= q + 8'd1;
              end else begin
                r <= r + 7'd1;
              end
            end else begin
              m <= m + 4'd1;
            end
          end
        end else begin
          if (d > 5'd1) begin
            d <= d - 5'd1;
          end else if (m == 4'd1) begin
            d <= 5'd31;
            m <= 4'd12;
            y <= y - 14'd1;
            if (r == 7'd0) begin
              r <= 7'd99;
              q <= q - 8'd1;
            end else begin
              r <= r - 7'd1;
            end
          end else begin
            // previous month length, same year
            m <= m - 4'd1;
            d <= dim_prev;
          end
        end
      end
    end
  end

  assign out_day   = d;
  assign out_month = m;
  assign out_year  = y;

endmodule

>>> rtl/calendar_date_stepper_core.sv
// top level of the gregorian date stepper: controller plus datapath
// depends on cds_pkg, cds_ctrl and cds_datapath
//
// Usage
//   An item is taken at a rising edge with start high and busy low; func,
//   in_day, in_month, in_year and day_count are sampled at that edge only.
//   The result (out_day, out_month, out_year, day_diff, clamped) is marked
//   by done, high for exactly one cycle; the receiver cannot stall it, so
//   it must take the result in that cycle. The date outputs keep showing
//   the stored date between items.
//   Add or subtract steps the date by day_count days, limited to MAX_STEP
//   and fewer if the range bound is hit, moving it by one day per cycle.
//   A load goes through a year split and a check; a difference goes
//   through a year split, a check, a day-number stage and a final stage
//   that takes the absolute difference.
//   busy is low again in the done cycle, so the next item may start there.
//   Reset is synchronous and active high; it loads EPOCH_YEAR-01-01 and
//   abandons any item in progress without a result.
module calendar_date_stepper_core #(
  parameter int unsigned EPOCH_YEAR = 1970,
  parameter int unsigned MAX_YEAR   = 9999,
  parameter int unsigned MAX_STEP   = 65535
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func,
  input  logic [4:0]  in_day,
  input  logic [3:0]  in_month,
  input  logic [13:0] in_year,
  input  logic [15:0] day_count,
  output logic        done,
  output logic [4:0]  out_day,
  output logic [3:0]  out_month,
  output logic [13:0] out_year,
  output logic [21:0] day_diff,
  output logic        clamped
);
  import cds_pkg::*;

  cds_cmd_t    cmd;
  cds_status_t status;

  cds_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .func   (func),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  cds_datapath #(
    .EPOCH_YEAR (EPOCH_YEAR),
    .MAX_YEAR   (MAX_YEAR),
    .MAX_STEP   (MAX_STEP)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .func      (func),
    .in_day    (in_day),
    .in_month  (in_month),
    .in_year   (in_year),
    .day_count (day_count),
    .status    (status),
    .out_day   (out_day),
    .out_month (out_month),
    .out_year  (out_year),
    .day_diff  (day_diff),
    .clamped   (clamped),
    .done      (done)
  );

endmodule

>>> rtl/cds_checker.sv
// port-level checks on the date stepper, bound onto the top level
// depends on calendar_date_stepper_core_assert.svh for the assertion macros
module cds_checker #(
  parameter int unsigned EPOCH_YEAR = 1970,
  parameter int unsigned MAX_YEAR   = 9999
) (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [4:0]  out_day,
  input logic [3:0]  out_month,
  input logic [13:0] out_year
);

`include "calendar_date_stepper_core_assert.svh"

  localparam logic [13:0] EPOCH_Y = 14'(EPOCH_YEAR);
  localparam logic [13:0] MAX_Y   = 14'(MAX_YEAR);

  logic date_in_range;

  assign date_in_range = (out_day >= 5'd1) && (out_day <= 5'd31) &&
                         (out_month >= 4'd1) && (out_month <= 4'd12) &&
                         (out_year >= EPOCH_Y) && (out_year <= MAX_Y);

  // busy is high in the cycle after an item is accepted
  `CDS_ASSERT_NXT(a_busy_after_start, start && !busy, busy, "item accepted but busy low")
  // a result always comes with the block ready for the next item
  `CDS_ASSERT_IMP(a_idle_on_done, done, !busy, "done while still busy")
  // no two results in consecutive cycles
  `CDS_ASSERT_NXT(a_done_single, done, !done, "done held for two cycles")
  // the reported date stays in the held range
  `CDS_ASSERT_IMP(a_date_range, done, date_in_range, "result date out of range")

endmodule

bind calendar_date_stepper_core cds_checker #(
  .EPOCH_YEAR (EPOCH_YEAR),
  .MAX_YEAR   (MAX_YEAR)
) u_cds_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .out_day   (out_day),
  .out_month (out_month),
  .out_year  (out_year)
);
